>>> hdl/fbba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbba_pkg
// Shared constants and types for the free block bitmap allocator.
// ----------------------------------------------------------------------------
package fbba_pkg;

    localparam int MAP_WORDS = 1024;
    localparam int WORD_BITS = 64;
    localparam int WIDX_W    = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int BLK_W     = 16;
    localparam int LEN_W     = 17;
    localparam int CNT_W     = 16;
    localparam int BSL_W     = 5;
    localparam int BYTES_W   = 32;
    localparam int PCNT_W    = BIT_W + 1;   // 0..64 within one word

    localparam logic [BSL_W-1:0]  BSL_RESET = 5'd10;
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_MARK  = 2'd2;
    localparam logic [1:0] CMD_SCAN  = 2'd3;

    // one bitmap word on its way into the scan unit
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [WIDX_W-1:0] index;
    } t_beat;

    typedef struct packed {
        logic             found;
        logic [BLK_W-1:0] start;
        logic [LEN_W-1:0] length;
        logic [CNT_W-1:0] count;
    } t_scan_res;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic                 run_found;
        logic [BLK_W-1:0]     run_start;
        logic [LEN_W-1:0]     run_length;
        logic [CNT_W-1:0]     run_count;
        logic                 clipped;
    } t_result;

endpackage
`default_nettype wire

>>> hdl/fbba_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbba_in_if
// Command channel: valid/ready plus the fields of one command item.
// ----------------------------------------------------------------------------
interface fbba_in_if
    import fbba_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_data;
    logic [BLK_W-1:0]     start_block;
    logic [BYTES_W-1:0]   byte_count;
    logic                 mark_value;

    modport source (
        output valid, command, word_index, word_data, start_block, byte_count,
               mark_value,
        input  ready
    );
    modport sink (
        input  valid, command, word_index, word_data, start_block, byte_count,
               mark_value,
        output ready
    );
endinterface
`default_nettype wire

>>> hdl/fbba_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbba_out_if
// Result channel: valid/ready plus the fields of one result item.
// ----------------------------------------------------------------------------
interface fbba_out_if
    import fbba_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] read_data;
    logic                 run_found;
    logic [BLK_W-1:0]     run_start;
    logic [LEN_W-1:0]     run_length;
    logic [CNT_W-1:0]     run_count;
    logic                 clipped;

    modport source (
        output valid, read_data, run_found, run_start, run_length, run_count, clipped,
        input  ready
    );
    modport sink (
        input  valid, read_data, run_found, run_start, run_length, run_count, clipped,
        output ready
    );
endinterface
`default_nettype wire

>>> hdl/fbba_scan_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbba_scan_unit
// Per-word free-run analysis and running largest-run accumulator.
// ----------------------------------------------------------------------------
module fbba_scan_unit
    import fbba_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_clear,
    input  wire t_beat                i_beat,
    input  wire logic [WORD_BITS-1:0] i_word,
    output logic                      o_done,
    output t_scan_res                 o_res
);

    localparam int LVLS = BIT_W;

    // ---- stage A: length of the 1-run ending at each bit ----
    logic [PCNT_W-1:0] z [0:LVLS][0:WORD_BITS-1];
    logic [PCNT_W-1:0] n_len [0:WORD_BITS-1];

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            z[0][j] = i_word[j] ? '0 : PCNT_W'(j + 1);
        end
        for (int l = 0; l < LVLS; l++) begin
            for (int j = 0; j < WORD_BITS; j++) begin
                if (j >= (1 << l) && z[l][j - (1 << l)] > z[l][j]) begin
                    z[l+1][j] = z[l][j - (1 << l)];
                end else begin
                    z[l+1][j] = z[l][j];
                end
            end
        end
        for (int j = 0; j < WORD_BITS; j++) begin
            n_len[j] = PCNT_W'(j + 1) - z[LVLS][j];
        end
    end

    logic [PCNT_W-1:0]    r_len [0:WORD_BITS-1];
    logic [WORD_BITS-1:0] r_a_word;
    t_beat                r_a_beat;

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_a_word <= i_word;
        if (!i_rst_n) begin
            r_a_beat <= '0;
        end else begin
            r_a_beat <= i_beat;
        end
    end

    // ---- stage B: word features ----
    logic [PCNT_W-1:0] mv  [0:LVLS][0:WORD_BITS-1];
    logic [BIT_W-1:0]  mp  [0:LVLS][0:WORD_BITS-1];
    logic [PCNT_W-1:0] n_p;
    logic [BIT_W:0]    n_rc;
    logic [BIT_W-1:0]  n_s;

    always_comb begin
        // internal runs only: a run touching bit 0 belongs to the prefix
        for (int j = 0; j < WORD_BITS; j++) begin
            mv[0][j] = (r_len[j] == PCNT_W'(j + 1)) ? '0 : r_len[j];
            mp[0][j] = BIT_W'(j);
        end
        for (int l = 0; l < LVLS; l++) begin
            for (int j = 0; j < (WORD_BITS >> (l + 1)); j++) begin
                if (mv[l][2*j] >= mv[l][2*j+1]) begin
                    mv[l+1][j] = mv[l][2*j];
                    mp[l+1][j] = mp[l][2*j];
                end else begin
                    mv[l+1][j] = mv[l][2*j+1];
                    mp[l+1][j] = mp[l][2*j+1];
                end
            end
            for (int j = (WORD_BITS >> (l + 1)); j < WORD_BITS; j++) begin
                mv[l+1][j] = '0;
                mp[l+1][j] = '0;
            end
        end
        n_s = mp[LVLS][0] - BIT_W'(mv[LVLS][0]) + BIT_W'(1);

        // trailing ones from bit 0
        n_p = PCNT_W'(WORD_BITS);
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!r_a_word[j]) begin
                n_p = PCNT_W'(j);
            end
        end

        // run starts above bit 0
        n_rc = '0;
        for (int j = 1; j < WORD_BITS; j++) begin
            n_rc = n_rc + (BIT_W + 1)'(r_a_word[j] & ~r_a_word[j-1]);
        end
    end

    logic [PCNT_W-1:0] r_b_p;
    logic [PCNT_W-1:0] r_b_t;
    logic [PCNT_W-1:0] r_b_m;
    logic [BIT_W-1:0]  r_b_s;
    logic [BIT_W:0]    r_b_rc;
    logic              r_b_all1;
    t_beat             r_b_beat;

    always_ff @(posedge i_clk) begin
        r_b_p    <= n_p;
        r_b_t    <= r_len[WORD_BITS-1];
        r_b_m    <= mv[LVLS][0];
        r_b_s    <= n_s;
        r_b_rc   <= n_rc;
        r_b_all1 <= &r_a_word;
        if (!i_rst_n) begin
            r_b_beat <= '0;
        end else begin
            r_b_beat <= r_a_beat;
        end
    end

    // ---- stage C: running accumulator, words in ascending order ----
    logic [LEN_W-1:0] r_best, n_best;
    logic [BLK_W-1:0] r_bst,  n_bst;
    logic [LEN_W-1:0] r_cur,  n_cur;
    logic [BLK_W-1:0] r_cst,  n_cst;
    logic [CNT_W-1:0] r_runs, n_runs;
    logic             r_done;

    logic [BLK_W-1:0] base;
    logic [LEN_W-1:0] plen;
    logic [BLK_W-1:0] pst;
    logic [LEN_W-1:0] best1;
    logic [BLK_W-1:0] bst1;
    logic             cur_nz;

    always_comb begin
        base   = {r_b_beat.index, {BIT_W{1'b0}}};
        cur_nz = (r_cur != '0);
        plen   = r_cur + LEN_W'(r_b_p);
        pst    = cur_nz ? r_cst : base;
        n_runs = r_runs + CNT_W'(r_b_rc) + CNT_W'((r_b_p != '0) && !cur_nz);

        // the prefix run comes first, then the longest internal run
        if ((r_b_p != '0) && (plen > r_best)) begin
            best1 = plen;
            bst1  = pst;
        end else begin
            best1 = r_best;
            bst1  = r_bst;
        end
        if (LEN_W'(r_b_m) > best1) begin
            n_best = LEN_W'(r_b_m);
            n_bst  = base + BLK_W'(r_b_s);
        end else begin
            n_best = best1;
            n_bst  = bst1;
        end

        if (r_b_all1) begin
            n_cur = plen;
            n_cst = pst;
        end else begin
            n_cur = LEN_W'(r_b_t);
            n_cst = base + BLK_W'(PCNT_W'(WORD_BITS) - r_b_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
            r_bst  <= '0;
            r_cur  <= '0;
            r_cst  <= '0;
            r_runs <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_b_beat.valid && r_b_beat.last;
            if (i_clear) begin
                r_best <= '0;
                r_bst  <= '0;
                r_cur  <= '0;
                r_cst  <= '0;
                r_runs <= '0;
            end else if (r_b_beat.valid) begin
                r_best <= n_best;
                r_bst  <= n_bst;
                r_cur  <= n_cur;
                r_cst  <= n_cst;
                r_runs <= n_runs;
            end
        end
    end

    assign o_done       = r_done;
    assign o_res.found  = (r_best != '0);
    assign o_res.start  = r_bst;
    assign o_res.length = r_best;
    assign o_res.count  = r_runs;

endmodule
`default_nettype wire

>>> hdl/free_block_bitmap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator
// Free-block bitmap: word access, range marking and largest free run search.
// ----------------------------------------------------------------------------
// The map holds 1024 words of 64 bits (bit j of word i is block i*64+j,
// 1 = free) in a single-port-write, registered-read memory. One command item
// is taken at a time and gives exactly one result item. A write stores the
// word and a read returns the registered word. A mark with a zero block count
// ends without touching memory and otherwise runs a read-modify-write
// pipeline over the memory port. A scan streams one word per cycle through
// the memory read port into the run analysis pipeline. Words are not cleared
// at reset; read, scan or partially mark only words already loaded.
// block_size_log2 resets to 10 and is written through i_cfg_we/i_cfg_wdata;
// the user must write it only while idle, as the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator
    import fbba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [BSL_W-1:0] i_cfg_wdata,
    fbba_in_if.sink               i_in,
    fbba_out_if.source            o_out
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_WR     = 4'd1;
    localparam logic [3:0] ST_RD     = 4'd2;
    localparam logic [3:0] ST_RDW    = 4'd3;
    localparam logic [3:0] ST_MCNT   = 4'd4;
    localparam logic [3:0] ST_MCLIP  = 4'd5;
    localparam logic [3:0] ST_MRUN   = 4'd6;
    localparam logic [3:0] ST_MDRAIN = 4'd7;
    localparam logic [3:0] ST_SCAN   = 4'd8;
    localparam logic [3:0] ST_SWAIT  = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    localparam int TOT_W = BLK_W + 1;     // holds the block count of the map
    localparam int CT_W  = BYTES_W + 1;   // block count before clipping

    // ---- registers ----
    logic [3:0]           r_state;
    logic [BSL_W-1:0]     r_bs_log2;
    logic [WIDX_W-1:0]    r_idx;
    logic [WORD_BITS-1:0] r_data;
    logic [BLK_W-1:0]     r_start;
    logic [BYTES_W-1:0]   r_bytes;
    logic                 r_val;
    logic [CT_W-1:0]      r_count;
    logic [BLK_W-1:0]     r_last;
    logic                 r_clip;
    logic [WIDX_W-1:0]    r_addr;
    t_result              r_res;
    t_result              r_out;
    logic                 r_out_valid;

    // mark write-back stage
    logic                 r_mk_vld;
    logic [WIDX_W-1:0]    r_mk_addr;
    logic [WORD_BITS-1:0] r_mk_mask;

    // bitmap memory
    logic [WORD_BITS-1:0] r_mem [0:MAP_WORDS-1];
    logic [WORD_BITS-1:0] r_mem_q;
    t_beat                r_sc_beat;

    logic                 accept;
    logic                 slot_free;
    logic [WIDX_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [CT_W-1:0]      unit_m1;
    logic [CT_W-1:0]      cnt_raw;
    logic [TOT_W-1:0]     avail;
    logic                 over;
    logic [TOT_W-1:0]     cnt_clip;
    logic [BIT_W-1:0]     lo_bit;
    logic [BIT_W-1:0]     hi_bit;
    logic [WORD_BITS-1:0] n_mask;

    logic                 scan_done;
    t_scan_res            scan_res;

    assign accept    = i_in.valid && i_in.ready;
    assign slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // ---- mark arithmetic ----
    always_comb begin
        // blocks = ceil(bytes / 2^log2)
        unit_m1  = (CT_W'(1) << r_bs_log2) - CT_W'(1);
        cnt_raw  = (CT_W'(r_bytes) + unit_m1) >> r_bs_log2;
        // blocks left from start to the end of the map, 1..65536
        avail    = TOT_W'(MAP_WORDS * WORD_BITS) - TOT_W'(r_start);
        over     = (r_count > CT_W'(avail));
        cnt_clip = over ? avail : r_count[TOT_W-1:0];

        // bit span inside the word being read
        lo_bit = (r_addr == r_start[BLK_W-1:BIT_W]) ? r_start[BIT_W-1:0] : '0;
        hi_bit = (r_addr == r_last[BLK_W-1:BIT_W]) ? r_last[BIT_W-1:0]
                                                     : BIT_W'(WORD_BITS - 1);
        n_mask = ({WORD_BITS{1'b1}} << lo_bit)
               & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
    end

    // ---- memory port muxing ----
    always_comb begin
        rd_addr = r_addr;
        if (r_state == ST_RD) begin
            rd_addr = r_idx;
        end
        wr_en   = 1'b0;
        wr_addr = r_mk_addr;
        wr_data = r_val ? (r_mem_q | r_mk_mask) : (r_mem_q & ~r_mk_mask);
        if (r_state == ST_WR) begin
            wr_en   = 1'b1;
            wr_addr = r_idx;
            wr_data = r_data;
        end else if (r_mk_vld) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    // ---- scan unit ----
    fbba_scan_unit u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (accept && (i_in.command == CMD_SCAN)),
        .i_beat  (r_sc_beat),
        .i_word  (r_mem_q),
        .o_done  (scan_done),
        .o_res   (scan_res)
    );

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        r_mk_addr <= r_addr;
        r_mk_mask <= n_mask;
        if (accept) begin
            r_idx   <= i_in.word_index;
            r_data  <= i_in.word_data;
            r_start <= i_in.start_block;
            r_bytes <= i_in.byte_count;
            r_val   <= i_in.mark_value;
        end
        if (r_state == ST_MCNT) begin
            r_count <= cnt_raw;
        end
        if (r_state == ST_MCLIP) begin
            // last block touched, used only when the count is at least one
            r_last <= BLK_W'(TOT_W'(r_start) + cnt_clip - TOT_W'(1));
            r_clip <= over;
        end
        if (r_state == ST_DONE && slot_free) begin
            r_out <= r_res;
        end
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bs_log2   <= BSL_RESET;
            r_addr      <= '0;
            r_res       <= '0;
            r_out_valid <= 1'b0;
            r_mk_vld    <= 1'b0;
            r_sc_beat   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_bs_log2 <= i_cfg_wdata;
            end

            r_mk_vld        <= (r_state == ST_MRUN);
            r_sc_beat.valid <= (r_state == ST_SCAN);
            r_sc_beat.last  <= (r_addr == LAST_WORD);
            r_sc_beat.index <= r_addr;

            if (r_state == ST_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_res  <= '0;
                        r_addr <= '0;
                        case (i_in.command)
                            CMD_WRITE: r_state <= ST_WR;
                            CMD_READ:  r_state <= ST_RD;
                            CMD_MARK:  r_state <= ST_MCNT;
                            CMD_SCAN:  r_state <= ST_SCAN;
                            default:   r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_WR: begin
                    r_state <= ST_DONE;
                end
                ST_RD: begin
                    r_state <= ST_RDW;
                end
                ST_RDW: begin
                    r_res.read_data <= r_mem_q;
                    r_state         <= ST_DONE;
                end
                ST_MCNT: begin
                    r_state <= ST_MCLIP;
                end
                ST_MCLIP: begin
                    r_addr <= r_start[BLK_W-1:BIT_W];
                    if (r_count == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_MRUN;
                    end
                end
                ST_MRUN: begin
                    // one word read per cycle, written back the next cycle
                    if (r_addr == r_last[BLK_W-1:BIT_W]) begin
                        r_res.clipped <= r_clip;
                        r_state       <= ST_MDRAIN;
                    end else begin
                        r_addr <= r_addr + WIDX_W'(1);
                    end
                end
                ST_MDRAIN: begin
                    r_state <= ST_DONE;
                end
                ST_SCAN: begin
                    if (r_addr == LAST_WORD) begin
                        r_state <= ST_SWAIT;
                    end else begin
                        r_addr <= r_addr + WIDX_W'(1);
                    end
                end
                ST_SWAIT: begin
                    if (scan_done) begin
                        r_res.run_found  <= scan_res.found;
                        r_res.run_start  <= scan_res.start;
                        r_res.run_length <= scan_res.length;
                        r_res.run_count  <= scan_res.count;
                        r_state          <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // ---- result channel ----
    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_out.read_data;
    assign o_out.run_found  = r_out.run_found;
    assign o_out.run_start  = r_out.run_start;
    assign o_out.run_length = r_out.run_length;
    assign o_out.run_count  = r_out.run_count;
    assign o_out.clipped    = r_out.clipped;

endmodule
`default_nettype wire
